/* hdl/lmep_pkg.sv */
// Package for the list-mode event word parser.
// Holds the result record type, the configuration bundle, register indexes,
// result kinds, status codes and header-length codes. No dependencies.
package lmep_pkg;

  localparam int CFG_ADDR_W = 3;

  localparam logic REG_SAT_ENERGY   = 1'b0;
  localparam logic REG_CRATE_STRIDE = 1'b1;

  localparam logic [1:0] KIND_EVENT  = 2'd0;
  localparam logic [1:0] KIND_TRACE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd1;
  localparam logic [2:0] ST_BAD_HLEN  = 3'd2;
  localparam logic [2:0] ST_BAD_ELEN  = 3'd3;
  localparam logic [2:0] ST_STATS     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam logic [4:0] HL_STATS = 5'd1;
  localparam logic [4:0] HL_4     = 5'd4;
  localparam logic [4:0] HL_8     = 5'd8;
  localparam logic [4:0] HL_12    = 5'd12;
  localparam logic [4:0] HL_16    = 5'd16;

  localparam logic [15:0] SAT_ENERGY_RST   = 16'd16383;
  localparam logic [9:0]  CRATE_STRIDE_RST = 10'd100;

  typedef struct packed {
    logic [15:0] saturated_energy;
    logic [9:0]  crate_stride;
  } lmep_cfg_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  channel;
    logic [3:0]  slot;
    logic [3:0]  crate;
    logic [15:0] module_id;
    logic [15:0] energy;
    logic [47:0] event_time;
    logic [15:0] cfd_time;
    logic [15:0] trace_length;
    logic [2:0]  flag_bits;
    logic [31:0] trace_pair;
    logic [2:0]  status;
  } lmep_result_t;

endpackage

/* hdl/lmep_cfg_regs.sv */
// Configuration registers of the list-mode event word parser.
// APB-style write and read of the saturated energy and the crate stride.
// Depends on lmep_pkg.
module lmep_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lmep_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output lmep_pkg::lmep_cfg_t            cfg
);

  logic [15:0] sat_energy_r;
  logic [9:0]  crate_stride_r;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_energy_r   <= lmep_pkg::SAT_ENERGY_RST;
      crate_stride_r <= lmep_pkg::CRATE_STRIDE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        lmep_pkg::REG_SAT_ENERGY:   sat_energy_r   <= pwdata[15:0];
        lmep_pkg::REG_CRATE_STRIDE: crate_stride_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lmep_pkg::REG_SAT_ENERGY:   prdata = {16'd0, sat_energy_r};
      lmep_pkg::REG_CRATE_STRIDE: prdata = {22'd0, crate_stride_r};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg.saturated_energy = sat_energy_r;
  assign cfg.crate_stride     = crate_stride_r;

endmodule

/* hdl/lmep_parser.sv */
// Parse state machine of the list-mode event word parser.
// Holds the buffer and event counters and latched header words, and forms
// the result for the word in the input register. Depends on lmep_pkg.
module lmep_parser #(
  parameter int MAX_BUFFER_WORDS = 8192
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [31:0]             word,
  input  logic                    start,
  input  lmep_pkg::lmep_cfg_t     cfg,
  output logic                    res_valid,
  output lmep_pkg::lmep_result_t  res
);

  localparam int BW = $clog2(MAX_BUFFER_WORDS + 1);

  typedef enum logic [3:0] {
    PH_LEN, PH_MOD, PH_H0, PH_H1, PH_H2, PH_H3, PH_TRACE, PH_SKIP, PH_DROP
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [BW-1:0] buf_left_r, buf_left_nxt;
  logic [7:0]    module_r, module_nxt;
  logic [11:0]   ewl_r, ewl_nxt;
  logic [31:0]   w0_r, w0_nxt;
  logic [31:0]   w2_r, w2_nxt;
  logic [31:0]   tlow_r, tlow_nxt;

  logic [BW-1:0] len;
  logic [4:0]    hl_in, hl_st, hl_m4;
  logic [11:0]   el_in, el_st, trace_idx;
  logic [15:0]   tl, len_sum;
  logic [3:0]    crate;
  logic [13:0]   stride_prod;

  assign len   = (word > 32'(MAX_BUFFER_WORDS)) ? BW'(MAX_BUFFER_WORDS) : word[BW-1:0];
  assign hl_in = word[16:12];
  assign el_in = word[28:17];
  assign hl_st = w0_r[16:12];
  assign el_st = w0_r[28:17];
  assign hl_m4 = hl_st - lmep_pkg::HL_4;
  assign tl    = word[31:16];
  assign crate = w0_r[11:8];
  assign stride_prod = cfg.crate_stride * crate;
  assign len_sum     = {1'b0, tl[15:1]} + {11'd0, hl_st};
  assign trace_idx   = el_st - 12'd4 - ewl_r;

  always_comb begin
    phase_nxt    = phase_r;
    buf_left_nxt = buf_left_r;
    module_nxt   = module_r;
    ewl_nxt      = ewl_r;
    w0_nxt       = w0_r;
    w2_nxt       = w2_r;
    tlow_nxt     = tlow_r;
    res_valid    = 1'b0;
    res          = '0;

    if (start || phase_r == PH_LEN) begin
      if (word == 32'd0) begin
        phase_nxt       = PH_LEN;
        buf_left_nxt    = '0;
        res_valid       = 1'b1;
        res.result_kind = lmep_pkg::KIND_STATUS;
        res.status      = lmep_pkg::ST_ZERO_LEN;
      end else if (len <= BW'(2)) begin
        phase_nxt       = (len == BW'(2)) ? PH_MOD : PH_LEN;
        buf_left_nxt    = (len == BW'(2)) ? BW'(1) : '0;
        res_valid       = 1'b1;
        res.result_kind = lmep_pkg::KIND_STATUS;
        res.status      = lmep_pkg::ST_EMPTY;
      end else begin
        phase_nxt    = PH_MOD;
        buf_left_nxt = len - BW'(1);
      end
    end else begin
      unique case (phase_r)
        PH_MOD: begin
          module_nxt = word[7:0];
          phase_nxt  = PH_H0;
        end
        PH_H0: begin
          if (hl_in == lmep_pkg::HL_STATS) begin
            res_valid       = 1'b1;
            res.result_kind = lmep_pkg::KIND_STATUS;
            res.status      = lmep_pkg::ST_STATS;
            ewl_nxt         = (el_in != 12'd0) ? el_in - 12'd1 : 12'd0;
            phase_nxt       = (ewl_nxt != 12'd0) ? PH_SKIP : PH_H0;
          end else if (hl_in != lmep_pkg::HL_4 && hl_in != lmep_pkg::HL_8 &&
                       hl_in != lmep_pkg::HL_12 && hl_in != lmep_pkg::HL_16) begin
            res_valid       = 1'b1;
            res.result_kind = lmep_pkg::KIND_STATUS;
            res.status      = lmep_pkg::ST_BAD_HLEN;
            phase_nxt       = PH_DROP;
          end else begin
            w0_nxt    = word;
            phase_nxt = PH_H1;
          end
        end
        PH_H1: begin
          tlow_nxt  = word;
          phase_nxt = PH_H2;
        end
        PH_H2: begin
          w2_nxt    = word;
          phase_nxt = PH_H3;
        end
        PH_H3: begin
          res_valid = 1'b1;
          if (len_sum != {4'd0, el_st}) begin
            res.result_kind = lmep_pkg::KIND_STATUS;
            res.status      = lmep_pkg::ST_BAD_ELEN;
            ewl_nxt         = (el_st >= 12'd4) ? el_st - 12'd4 : 12'd0;
            phase_nxt       = (ewl_nxt != 12'd0) ? PH_SKIP : PH_H0;
          end else begin
            res.result_kind  = lmep_pkg::KIND_EVENT;
            res.channel      = w0_r[3:0];
            res.slot         = w0_r[7:4];
            res.crate        = crate;
            res.module_id    = 16'(module_r) + 16'(stride_prod);
            res.energy       = w0_r[30] ? cfg.saturated_energy : word[15:0];
            res.event_time   = {w2_r[15:0], tlow_r};
            res.cfd_time     = w2_r[31:16];
            res.trace_length = tl;
            res.flag_bits    = w0_r[31:29];
            res.status       = lmep_pkg::ST_OK;
            ewl_nxt          = el_st - 12'd4;
            phase_nxt        = (ewl_nxt != 12'd0) ? PH_TRACE : PH_H0;
          end
        end
        PH_TRACE: begin
          if (trace_idx >= {7'd0, hl_m4}) begin
            res_valid       = 1'b1;
            res.result_kind = lmep_pkg::KIND_TRACE;
            res.trace_pair  = word;
            res.status      = lmep_pkg::ST_OK;
          end
          ewl_nxt = (ewl_r != 12'd0) ? ewl_r - 12'd1 : 12'd0;
          if (ewl_nxt == 12'd0) begin
            phase_nxt = PH_H0;
          end
        end
        PH_SKIP: begin
          ewl_nxt = (ewl_r != 12'd0) ? ewl_r - 12'd1 : 12'd0;
          if (ewl_nxt == 12'd0) begin
            phase_nxt = PH_H0;
          end
        end
        default: phase_nxt = PH_DROP;
      endcase
      buf_left_nxt = (buf_left_r != '0) ? buf_left_r - BW'(1) : '0;
      if (buf_left_nxt == '0) begin
        phase_nxt = PH_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN;
      buf_left_r <= '0;
      module_r   <= '0;
      ewl_r      <= '0;
      w0_r       <= '0;
      w2_r       <= '0;
      tlow_r     <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      buf_left_r <= buf_left_nxt;
      module_r   <= module_nxt;
      ewl_r      <= ewl_nxt;
      w0_r       <= w0_nxt;
      w2_r       <= w2_nxt;
      tlow_r     <= tlow_nxt;
    end
  end

  a_buf_left_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_LEN |-> buf_left_r != '0)
    else $error("parser is inside a buffer with no words left");

  a_event_words_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP || phase_r == PH_TRACE) |-> ewl_r != 12'd0)
    else $error("skip or trace phase with no event words left");

  a_event_from_h3: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.result_kind == lmep_pkg::KIND_EVENT
      |-> phase_r == PH_H3 && !start)
    else $error("event record formed outside header word 3");

  a_trace_advances: assert property (@(posedge clk) disable iff (!rst_n)
    step && !start && phase_r == PH_TRACE |=> ewl_r != $past(ewl_r) || phase_r == PH_LEN)
    else $error("trace phase did not consume an event word");

endmodule

/* hdl/list_mode_event_word_parser_core.sv */
// Top level of the list-mode event word parser.
// Input register, parse state machine, result register and configuration port.
// Depends on lmep_pkg, lmep_cfg_regs and lmep_parser.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_ready  | in_data_word, in_buffer_start
//   result   | out_valid/ out_ready | out_result_kind ... out_status
//   config   | psel/penable/pready  | paddr, pwdata, prdata (APB-style)
//
// One word is accepted per cycle while the result register is not stalled;
// a word passes the input register and the single decode stage, and any
// result enters the result register. Synchronous reset needs no clearing pass.
// A stalled result holds the decode stage, which then holds the input register.
module list_mode_event_word_parser_core #(
  parameter int MAX_BUFFER_WORDS = 8192
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     in_data_word,
  input  logic                            in_buffer_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_result_kind,
  output logic [3:0]                      out_channel,
  output logic [3:0]                      out_slot,
  output logic [3:0]                      out_crate,
  output logic [15:0]                     out_module_id,
  output logic [15:0]                     out_energy,
  output logic [47:0]                     out_event_time,
  output logic [15:0]                     out_cfd_time,
  output logic [15:0]                     out_trace_length,
  output logic [2:0]                      out_flag_bits,
  output logic [31:0]                     out_trace_pair,
  output logic [2:0]                      out_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lmep_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  lmep_pkg::lmep_cfg_t    cfg;
  lmep_pkg::lmep_result_t res;
  lmep_pkg::lmep_result_t out_r;
  logic                   res_valid;
  logic                   in_v_r;
  logic [31:0]            in_word_r;
  logic                   in_start_r;
  logic                   out_v_r;
  logic                   step;

  assign step     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step;

  lmep_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmep_parser #(
    .MAX_BUFFER_WORDS (MAX_BUFFER_WORDS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (in_word_r),
    .start     (in_start_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (step) begin
        out_v_r <= res_valid;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r  <= in_data_word;
      in_start_r <= in_buffer_start;
    end
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_result_kind  = out_r.result_kind;
  assign out_channel      = out_r.channel;
  assign out_slot         = out_r.slot;
  assign out_crate        = out_r.crate;
  assign out_module_id    = out_r.module_id;
  assign out_energy       = out_r.energy;
  assign out_event_time   = out_r.event_time;
  assign out_cfd_time     = out_r.cfd_time;
  assign out_trace_length = out_r.trace_length;
  assign out_flag_bits    = out_r.flag_bits;
  assign out_trace_pair   = out_r.trace_pair;
  assign out_status       = out_r.status;

endmodule
